/* rtl/lfa_pkg.sv */
// Types, constants and direction table function for the line fit angle sweep.
package lfa_pkg;

  localparam int COORD_W = 16;
  localparam int CTR_W   = 20;
  localparam int Q15_W   = 16;
  localparam int DX_W    = 21;
  localparam int PROD_W  = 37;
  localparam int DIFF_W  = 38;
  localparam int IDX_W   = 8;

  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam int TERMS = 8;

  localparam logic [63:0] SIN_DEN [TERMS] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};
  localparam logic [63:0] COS_DEN [TERMS] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                              64'd90, 64'd132, 64'd182, 64'd240};

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } lfa_in_t;

  typedef struct packed {
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
    logic signed [Q15_W-1:0] dir_cos;
    logic signed [Q15_W-1:0] dir_sin;
    logic [IDX_W-1:0]        angle_index;
    logic                    overflow;
  } lfa_out_t;

  typedef struct packed {
    logic in_take;
    logic div_start;
    logic sw_start;
    logic rd_issue;
    logic cmp;
    logic out_load;
  } lfa_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rd_last;
    logic pipe_busy;
    logic ang_last;
    logic out_free;
  } lfa_sts_t;

  typedef enum logic [7:0] {
    ST_LOAD     = 8'b0000_0001,
    ST_DIV_GO   = 8'b0000_0010,
    ST_DIV_WAIT = 8'b0000_0100,
    ST_SW_START = 8'b0000_1000,
    ST_SWEEP    = 8'b0001_0000,
    ST_DRAIN    = 8'b0010_0000,
    ST_COMPARE  = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } lfa_state_t;

  function automatic logic [Q15_W-1:0] to_q15(input logic signed [63:0] acc);
    logic signed [63:0] a;
    logic signed [63:0] v;
    a = (acc < 0) ? 64'sd0 : acc;
    v = (a + 64'sd16384) >>> 15;
    return (v > 64'sd32767) ? 16'sd32767 : v[Q15_W-1:0];
  endfunction

  // t: angle in 2^-32 turn; returns {cos, sin} in Q1.15
  function automatic logic [2*Q15_W-1:0] dir_of(input logic [31:0] t);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] acc_s;
    logic signed [63:0] acc_c;
    logic [Q15_W-1:0]   cq;
    logic [Q15_W-1:0]   sq;
    logic [Q15_W-1:0]   c;
    logic [Q15_W-1:0]   s;
    quad  = t[31:30];
    r     = {34'd0, t[29:0]};
    x     = (r * HALF_PI_Q31 + (64'd1 << 30)) >> 31;
    x2    = (x * x) >> 30;
    ts    = x;
    tc    = ONE_Q30;
    acc_s = $signed(x);
    acc_c = $signed(ONE_Q30);
    for (int k = 0; k < TERMS; k++) begin
      ts = ((ts * x2) >> 30) / SIN_DEN[k];
      tc = ((tc * x2) >> 30) / COS_DEN[k];
      if ((k % 2) == 0) begin
        acc_s = acc_s - $signed(ts);
        acc_c = acc_c - $signed(tc);
      end else begin
        acc_s = acc_s + $signed(ts);
        acc_c = acc_c + $signed(tc);
      end
    end
    cq = to_q15(acc_c);
    sq = to_q15(acc_s);
    case (quad)
      2'd0:    begin c = cq;  s = sq;  end
      2'd1:    begin c = -sq; s = cq;  end
      2'd2:    begin c = -cq; s = -sq; end
      default: begin c = sq;  s = -cq; end
    endcase
    return {c, s};
  endfunction

endpackage

/* rtl/lfa_ram.sv */
// Generic single write, single read RAM with registered read data.
module lfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lfa_div.sv */
// Two-lane restoring divider forming the rounded Q.4 mean of both coordinates.
module lfa_div #(
  parameter int CNT_W = 11
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [lfa_pkg::COORD_W+CNT_W-1:0] sum_x,
  input  logic signed [lfa_pkg::COORD_W+CNT_W-1:0] sum_y,
  input  logic [CNT_W-1:0]                       cnt,
  output logic                                   done,
  output logic signed [lfa_pkg::CTR_W-1:0]       cx,
  output logic signed [lfa_pkg::CTR_W-1:0]       cy
);
  import lfa_pkg::*;

  localparam int SUM_W = COORD_W + CNT_W;
  localparam int NUM_W = SUM_W + 6;
  localparam int DEN_W = CNT_W + 1;
  localparam int BIT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_x_r, num_y_r;
  logic [DEN_W-1:0] rem_x_r, rem_y_r, den_r;
  logic             neg_x_r, neg_y_r;
  logic [BIT_W-1:0] bit_r;
  logic             busy_r, done_r;

  logic [SUM_W-1:0] mag_x, mag_y;
  logic [DEN_W:0]   trial_x, trial_y;
  logic             ge_x, ge_y;
  logic [CTR_W-1:0] q_x, q_y;

  assign mag_x   = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
  assign mag_y   = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
  assign trial_x = {rem_x_r, num_x_r[NUM_W-1]};
  assign trial_y = {rem_y_r, num_y_r[NUM_W-1]};
  assign ge_x    = trial_x >= {1'b0, den_r};
  assign ge_y    = trial_y >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= BIT_W'(NUM_W);
      end else if (busy_r) begin
        bit_r <= bit_r - 1'b1;
        if (bit_r == BIT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_x_r <= {1'b0, mag_x, 5'b0} + NUM_W'(cnt);
      num_y_r <= {1'b0, mag_y, 5'b0} + NUM_W'(cnt);
      rem_x_r <= '0;
      rem_y_r <= '0;
      den_r   <= {cnt, 1'b0};
      neg_x_r <= sum_x[SUM_W-1];
      neg_y_r <= sum_y[SUM_W-1];
    end else if (busy_r) begin
      rem_x_r <= ge_x ? DEN_W'(trial_x - {1'b0, den_r}) : trial_x[DEN_W-1:0];
      rem_y_r <= ge_y ? DEN_W'(trial_y - {1'b0, den_r}) : trial_y[DEN_W-1:0];
      num_x_r <= {num_x_r[NUM_W-2:0], ge_x};
      num_y_r <= {num_y_r[NUM_W-2:0], ge_y};
    end
  end

  assign q_x  = num_x_r[CTR_W-1:0];
  assign q_y  = num_y_r[CTR_W-1:0];
  assign cx   = neg_x_r ? CTR_W'(~q_x + 1'b1) : q_x;
  assign cy   = neg_y_r ? CTR_W'(~q_y + 1'b1) : q_y;
  assign done = done_r;

endmodule

/* rtl/lfa_dp.sv */
// Datapath: point store, sums, mean divider, distance pipeline and best-angle tracking.
module lfa_dp #(
  parameter int MAX_POINTS  = 1024,
  parameter int ANGLE_STEPS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lfa_pkg::lfa_cmd_t cmd,
  output lfa_pkg::lfa_sts_t sts,
  input  lfa_pkg::lfa_in_t  in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output lfa_pkg::lfa_out_t out_data
);
  import lfa_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int SUM_W = COORD_W + CNT_W;
  localparam int ANG_W = $clog2(ANGLE_STEPS);
  localparam int TOT_W = DIFF_W + CNT_W;

  logic [2*Q15_W-1:0] tab [ANGLE_STEPS];

  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_tab
    localparam logic [63:0] T = (64'(g) << 32) / 64'(ANGLE_STEPS);
    assign tab[g] = dir_of(T[31:0]);
  end

  logic [CNT_W-1:0]        cnt_r, rd_r;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r;
  logic                    dropped_r;
  logic [ANG_W-1:0]        ang_r, best_ang_r;
  logic signed [Q15_W-1:0] cs_c_r, cs_s_r, best_c_r, best_s_r;
  logic [TOT_W-1:0]        total_r, best_sum_r;
  logic                    v1_r, v2_r, v3_r, v4_r;
  logic signed [DX_W-1:0]  dx_r, dy_r;
  logic signed [PROD_W-1:0] ps_r, pc_r;
  logic signed [DIFF_W-1:0] df_r;
  logic                    out_valid_r;
  lfa_out_t                out_r;

  logic                    store_ok;
  logic [2*COORD_W-1:0]    rdata;
  logic signed [COORD_W-1:0] rx, ry;
  logic                    div_done;
  logic signed [CTR_W-1:0] cx, cy;
  logic signed [PROD_W-1:0] ps_nxt, pc_nxt;
  logic [DIFF_W-1:0]       abs_df;
  logic [ANG_W+IDX_W-1:0]  ang_ext;

  assign store_ok = cnt_r < CNT_W'(MAX_POINTS);

  lfa_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (cmd.in_take && store_ok),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_data.point_x, in_data.point_y}),
    .re    (cmd.rd_issue),
    .raddr (rd_r[AW-1:0]),
    .rdata (rdata)
  );

  lfa_div #(.CNT_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .sum_x (sum_x_r),
    .sum_y (sum_y_r),
    .cnt   (cnt_r),
    .done  (div_done),
    .cx    (cx),
    .cy    (cy)
  );

  assign rx     = rdata[2*COORD_W-1:COORD_W];
  assign ry     = rdata[COORD_W-1:0];
  assign ps_nxt = dx_r * cs_s_r;
  assign pc_nxt = dy_r * cs_c_r;
  assign abs_df = df_r[DIFF_W-1] ? DIFF_W'(-df_r) : DIFF_W'(df_r);
  assign ang_ext = {{IDX_W{1'b0}}, best_ang_r};

  // load and per-set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.out_load) begin
      cnt_r     <= '0;
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.in_take) begin
      if (store_ok) begin
        cnt_r   <= cnt_r + 1'b1;
        sum_x_r <= sum_x_r + SUM_W'(in_data.point_x);
        sum_y_r <= sum_y_r + SUM_W'(in_data.point_y);
      end else begin
        dropped_r <= 1'b1;
      end
    end
  end

  // sweep control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r <= '0;
      rd_r  <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      v1_r <= cmd.rd_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (cmd.sw_start) begin
        rd_r <= '0;
      end else if (cmd.rd_issue) begin
        rd_r <= rd_r + 1'b1;
      end
      if (cmd.cmp) begin
        ang_r <= sts.ang_last ? '0 : ang_r + 1'b1;
      end
    end
  end

  // distance pipeline and best tracking
  always_ff @(posedge clk) begin
    if (cmd.sw_start) begin
      {cs_c_r, cs_s_r} <= tab[ang_r];
    end
    if (v1_r) begin
      dx_r <= {rx[COORD_W-1], rx, 4'b0} - {cx[CTR_W-1], cx};
      dy_r <= {ry[COORD_W-1], ry, 4'b0} - {cy[CTR_W-1], cy};
    end
    if (v2_r) begin
      ps_r <= ps_nxt;
      pc_r <= pc_nxt;
    end
    if (v3_r) begin
      df_r <= DIFF_W'(ps_r) - DIFF_W'(pc_r);
    end
    if (cmd.sw_start) begin
      total_r <= '0;
    end else if (v4_r) begin
      total_r <= total_r + TOT_W'(abs_df);
    end
    if (cmd.cmp && (ang_r == '0 || total_r < best_sum_r)) begin
      best_sum_r <= total_r;
      best_ang_r <= ang_r;
      best_c_r   <= cs_c_r;
      best_s_r   <= cs_s_r;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.center_x    <= cx;
      out_r.center_y    <= cy;
      out_r.dir_cos     <= best_c_r;
      out_r.dir_sin     <= best_s_r;
      out_r.angle_index <= ang_ext[IDX_W-1:0];
      out_r.overflow    <= dropped_r;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.rd_last   = rd_r == CNT_W'(cnt_r - 1'b1);
  assign sts.pipe_busy = v1_r | v2_r | v3_r | v4_r;
  assign sts.ang_last  = ang_r == ANG_W'(ANGLE_STEPS - 1);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/lfa_ctrl.sv */
// Controller state machine sequencing load, mean division, angle sweep and output.
module lfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  lfa_pkg::lfa_sts_t sts,
  output lfa_pkg::lfa_cmd_t cmd
);
  import lfa_pkg::*;

  lfa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready    = 1'b1;
        cmd.in_take = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_SW_START;
        end
      end
      ST_SW_START: begin
        cmd.sw_start = 1'b1;
        state_nxt    = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.rd_issue = 1'b1;
        if (sts.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd.cmp   = 1'b1;
        state_nxt = sts.ang_last ? ST_DONE : ST_SW_START;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

/* rtl/line_fit_angle_sweep.sv */
// Top level of the orthogonal line fit by angle search.
// Points are taken one per cycle and written to the point store until the word
// with last_point set. The block then stops taking points while it forms the
// mean centre with a bit-serial divider and sweeps the ANGLE_STEPS directions:
// each angle streams every stored point through the store read port and a
// four-stage distance pipeline. The result word is held in an output register;
// loading of the next set starts as soon as it is written there. Points past
// MAX_POINTS are dropped and flagged.
module line_fit_angle_sweep #(
  parameter int MAX_POINTS  = 1024,
  parameter int ANGLE_STEPS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lfa_pkg::lfa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lfa_pkg::lfa_out_t out_data
);
  import lfa_pkg::*;

  lfa_cmd_t cmd;
  lfa_sts_t sts;

  lfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_point),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfa_dp #(.MAX_POINTS(MAX_POINTS), .ANGLE_STEPS(ANGLE_STEPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
